// File: rtl/clt_pkg.sv
// shared types, constants and escape table for the command line tokenizer
`timescale 1ns / 1ps

package clt_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] ChrNul    = 8'h00;
  localparam logic [ByteW-1:0] ChrSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChrDquote = 8'h22;
  localparam logic [ByteW-1:0] ChrSquote = 8'h27;
  localparam logic [ByteW-1:0] ChrBslash = 8'h5C;

  // parse mode, one-hot
  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_DQ       = 6'b000010,
    MODE_DQ_ESC   = 6'b000100,
    MODE_SQ       = 6'b001000,
    MODE_WORD     = 6'b010000,
    MODE_WORD_ESC = 6'b100000
  } mode_e;

  // results of one input byte, in order: character, token end, line end
  typedef struct packed {
    logic             has_char;
    logic [ByteW-1:0] chr;
    logic             has_te;
    logic             has_le;
  } clt_res_t;

  function automatic logic [ByteW-1:0] map_escape(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] t;
    unique case (c)
      8'h61:   t = 8'h07; // a
      8'h62:   t = 8'h08; // b
      8'h74:   t = 8'h09; // t
      8'h6E:   t = 8'h0A; // n
      8'h76:   t = 8'h0B; // v
      8'h66:   t = 8'h0C; // f
      8'h72:   t = 8'h0D; // r
      8'h5C:   t = 8'h5C;
      8'h22:   t = 8'h22;
      8'h30:   t = 8'h00; // escaped zero cuts the token
      default: t = c;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/command_line_tokenizer.sv
// command line tokenizer top level: input register, parser, result serializer
//
//   beat   direction  handshake              payload
//   in     input      in_valid_i/in_stall_o  byte_req_i
//   out    output     out_valid_o/out_stall_i data_o, token_end_o, line_end_o
//
// one byte enters per cycle while in_stall_o is low; its results leave one beat
// per cycle while out_stall_i is low, so a byte that yields k beats (0..3) holds
// the result register until its last beat is taken
// rst_ni clears the parse state and all valid flags; no clearing pass
// a stalled output holds its beat; the input register stalls once the next
// byte cannot move into the result register
`timescale 1ns / 1ps

module command_line_tokenizer
  import clt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] byte_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] data_o,
  output logic             token_end_o,
  output logic             line_end_o
);

  logic             in_v_q;
  logic [ByteW-1:0] byte_q;
  logic             can_load;
  logic             move;
  clt_res_t         res;

  assign move       = in_v_q && can_load;
  assign in_stall_o = in_v_q && !can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= byte_req_i;
    end
  end

  clt_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (move),
    .byte_i (byte_q),
    .res_o  (res)
  );

  clt_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (move),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (data_o),
    .token_end_o (token_end_o),
    .line_end_o  (line_end_o)
  );

endmodule

// File: rtl/clt_parser.sv
// parse state and per-byte decode into a result group
`timescale 1ns / 1ps

module clt_parser
  import clt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [ByteW-1:0] byte_i,
  output clt_res_t         res_o
);

  mode_e mode_q, mode_d;
  logic  cut_q, cut_d;

  always_comb begin
    logic [ByteW-1:0] t;
    t      = map_escape(byte_i);
    res_o  = '0;
    mode_d = mode_q;
    cut_d  = cut_q;
    unique case (mode_q)
      MODE_DQ, MODE_SQ, MODE_WORD: begin
        if (byte_i == ChrNul) begin
          res_o.has_te = 1'b1;
          res_o.has_le = 1'b1;
          mode_d       = MODE_IDLE;
          cut_d        = 1'b0;
        end else if ((mode_q == MODE_DQ && byte_i == ChrDquote) ||
                     (mode_q == MODE_SQ && byte_i == ChrSquote) ||
                     (mode_q == MODE_WORD && byte_i <= ChrSpace)) begin
          res_o.has_te = 1'b1;
          mode_d       = MODE_IDLE;
          cut_d        = 1'b0;
        end else if (mode_q != MODE_SQ && byte_i == ChrBslash) begin
          mode_d = (mode_q == MODE_DQ) ? MODE_DQ_ESC : MODE_WORD_ESC;
        end else begin
          res_o.has_char = !cut_q;
          res_o.chr      = byte_i;
        end
      end
      MODE_DQ_ESC, MODE_WORD_ESC: begin
        if (byte_i == ChrNul) begin
          // trailing lone backslash is kept
          res_o.has_char = !cut_q;
          res_o.chr      = ChrBslash;
          res_o.has_te   = 1'b1;
          res_o.has_le   = 1'b1;
          mode_d         = MODE_IDLE;
          cut_d          = 1'b0;
        end else begin
          if (t == ChrNul) begin
            cut_d = 1'b1;
          end else begin
            res_o.has_char = !cut_q;
            res_o.chr      = t;
          end
          mode_d = (mode_q == MODE_DQ_ESC) ? MODE_DQ : MODE_WORD;
        end
      end
      default: begin
        // idle, and any stray code
        mode_d = MODE_IDLE;
        if (byte_i == ChrNul) begin
          res_o.has_le = 1'b1;
          cut_d        = 1'b0;
        end else if (byte_i <= ChrSpace) begin
          mode_d = MODE_IDLE;
        end else if (byte_i == ChrDquote) begin
          cut_d  = 1'b0;
          mode_d = MODE_DQ;
        end else if (byte_i == ChrSquote) begin
          cut_d  = 1'b0;
          mode_d = MODE_SQ;
        end else if (byte_i == ChrBslash) begin
          cut_d  = 1'b0;
          mode_d = MODE_WORD_ESC;
        end else begin
          cut_d          = 1'b0;
          mode_d         = MODE_WORD;
          res_o.has_char = 1'b1;
          res_o.chr      = byte_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cut_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      cut_q  <= cut_d;
    end
  end

  // a zero byte always closes the line and leaves the parser clean
  a_line_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && byte_i == ChrNul) |=> (mode_q == MODE_IDLE && !cut_q))
    else $error("parser not idle after line end");

  a_le_only_on_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_i != ChrNul) |-> !res_o.has_le)
    else $error("line end without zero byte");

endmodule

// File: rtl/clt_serializer.sv
// result group register, sends its beats one per cycle while out_stall_i is low
`timescale 1ns / 1ps

module clt_serializer
  import clt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  clt_res_t         res_i,
  output logic             can_load_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] data_o,
  output logic             token_end_o,
  output logic             line_end_o
);

  clt_res_t grp_q, grp_d;
  logic     take;
  logic     last;

  assign out_valid_o = grp_q.has_char | grp_q.has_te | grp_q.has_le;
  assign take        = out_valid_o && !out_stall_i;
  assign last        = $countones({grp_q.has_char, grp_q.has_te, grp_q.has_le}) == 1;
  assign can_load_o  = !out_valid_o || (take && last);

  assign data_o      = grp_q.has_char ? grp_q.chr : ChrNul;
  assign token_end_o = !grp_q.has_char && grp_q.has_te;
  assign line_end_o  = !grp_q.has_char && !grp_q.has_te && grp_q.has_le;

  always_comb begin
    grp_d = grp_q;
    if (load_i) begin
      grp_d = res_i;
    end else if (take) begin
      // drop the beat just sent
      priority if (grp_q.has_char) begin
        grp_d.has_char = 1'b0;
      end else if (grp_q.has_te) begin
        grp_d.has_te = 1'b0;
      end else begin
        grp_d.has_le = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
    end else begin
      grp_q <= grp_d;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!out_valid_o || (take && last)))
    else $error("result group overwritten before drained");

  a_char_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !load_i && (token_end_o || line_end_o)) |=> !grp_q.has_char)
    else $error("character after a mark in one group");

endmodule
